### src/iptl_pkg.sv
// Shared constants, command codes and the result record of the IPv4 prefix
// trie lookup block. Depends on nothing; every other file of the block uses it.
`default_nettype none

package iptl_pkg;

    // Node pool and key geometry.
    localparam int NodeCount = 1024;
    localparam int KeyBits   = 32;
    localparam int ValueBits = 16;

    localparam int NodeIdxW  = $clog2(NodeCount);
    localparam int FreeW     = $clog2(NodeCount + 1);
    localparam int StepW     = $clog2(KeyBits + 1);

    // Widths of the input fields that are fixed by the port list.
    localparam int CmdW      = 2;
    localparam int PlenW     = 6;

    // Command codes.
    localparam logic [CmdW-1:0] CmdInsert = 2'd0;
    localparam logic [CmdW-1:0] CmdLookup = 2'd1;
    localparam logic [CmdW-1:0] CmdClear  = 2'd2;

    // Status codes.
    localparam logic StatusDone     = 1'b0;
    localparam logic StatusPoolFull = 1'b1;

    typedef struct packed {
        logic                 found;
        logic [ValueBits-1:0] match_value;
        logic                 status;
    } t_result;

endpackage

`default_nettype wire

### src/iptl_engine.sv
// Trie walker of the IPv4 prefix trie lookup block: the node memory, the
// free-node counter and the per-bit walk for insert, lookup and clear.
// Depends on iptl_pkg.
`default_nettype none

module iptl_engine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [iptl_pkg::CmdW-1:0]           i_cmd,
    input  wire logic [iptl_pkg::KeyBits-1:0]        i_address,
    input  wire logic [iptl_pkg::PlenW-1:0]          i_prefix_length,
    input  wire logic [iptl_pkg::ValueBits-1:0]      i_entry_value,
    output logic                                     o_busy,
    output logic                                     o_res_valid,
    output iptl_pkg::t_result                        o_res,
    input  wire logic                                i_res_ready
);

    typedef struct packed {
        logic [iptl_pkg::NodeIdxW-1:0]  left;
        logic [iptl_pkg::NodeIdxW-1:0]  right;
        logic                           valid;
        logic [iptl_pkg::ValueBits-1:0] value;
    } t_node;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    t_state                            r_state, n_state;
    logic [iptl_pkg::CmdW-1:0]         r_cmd, n_cmd;
    logic [iptl_pkg::KeyBits-1:0]      r_key, n_key;
    logic [iptl_pkg::StepW-1:0]        r_limit, n_limit;
    logic [iptl_pkg::ValueBits-1:0]    r_value, n_value;
    logic [iptl_pkg::StepW-1:0]        r_step, n_step;
    logic [iptl_pkg::NodeIdxW-1:0]     r_cur, n_cur;
    logic                              r_fresh, n_fresh;
    logic                              r_root_ok, n_root_ok;
    logic [iptl_pkg::FreeW-1:0]        r_next_free, n_next_free;
    iptl_pkg::t_result                 r_hold, n_hold;

    // Node memory with a registered read port.
    t_node                             r_mem [iptl_pkg::NodeCount];
    t_node                             r_node_q;

    logic                              rd_en;
    logic [iptl_pkg::NodeIdxW-1:0]     rd_addr;
    logic                              wr_en;
    t_node                             wr_data;

    t_node                             node_d;
    logic                              key_bit;
    logic [iptl_pkg::NodeIdxW-1:0]     child;
    logic                              pool_full;
    logic                              fin;
    iptl_pkg::t_result                 res;
    logic [iptl_pkg::NodeIdxW-1:0]     new_idx;

    // A fresh node was allocated in this walk and is known to be empty; its
    // memory entry is written when an insert walk leaves it.
    assign node_d    = r_fresh ? '0 : r_node_q;
    assign key_bit   = r_key[iptl_pkg::KeyBits-1];
    assign child     = key_bit ? node_d.right : node_d.left;
    assign pool_full = (r_next_free >= iptl_pkg::FreeW'(iptl_pkg::NodeCount));
    assign new_idx   = r_next_free[iptl_pkg::NodeIdxW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_limit     = r_limit;
        n_value     = r_value;
        n_step      = r_step;
        n_cur       = r_cur;
        n_fresh     = r_fresh;
        n_root_ok   = r_root_ok;
        n_next_free = r_next_free;
        n_hold      = r_hold;
        rd_en       = 1'b0;
        rd_addr     = child;
        wr_en       = 1'b0;
        wr_data     = node_d;
        fin         = 1'b0;
        res         = '0;
        o_res_valid = 1'b0;
        o_res       = r_hold;

        unique case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_key   = i_address;
                    n_value = i_entry_value;
                    if (i_prefix_length > iptl_pkg::PlenW'(iptl_pkg::KeyBits)) begin
                        n_limit = iptl_pkg::StepW'(iptl_pkg::KeyBits);
                    end else begin
                        n_limit = iptl_pkg::StepW'(i_prefix_length);
                    end
                    n_step  = '0;
                    n_cur   = '0;
                    // The root only lives in memory once something wrote it.
                    n_fresh = !r_root_ok;
                    rd_en   = r_root_ok;
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                unique case (r_cmd)
                    iptl_pkg::CmdInsert: begin
                        if (r_step == r_limit) begin
                            wr_en         = 1'b1;
                            wr_data.valid = 1'b1;
                            wr_data.value = r_value;
                            fin           = 1'b1;
                        end else if (child != '0) begin
                            rd_en   = 1'b1;
                            n_cur   = child;
                            n_fresh = 1'b0;
                            n_step  = r_step + iptl_pkg::StepW'(1);
                            n_key   = {r_key[iptl_pkg::KeyBits-2:0], 1'b0};
                        end else if (pool_full) begin
                            // Leave a freshly allocated node empty in memory.
                            wr_en      = r_fresh;
                            fin        = 1'b1;
                            res.status = iptl_pkg::StatusPoolFull;
                        end else begin
                            wr_en = 1'b1;
                            if (key_bit) begin
                                wr_data.right = new_idx;
                            end else begin
                                wr_data.left = new_idx;
                            end
                            n_cur       = new_idx;
                            n_fresh     = 1'b1;
                            n_next_free = r_next_free + iptl_pkg::FreeW'(1);
                            n_step      = r_step + iptl_pkg::StepW'(1);
                            n_key       = {r_key[iptl_pkg::KeyBits-2:0], 1'b0};
                        end
                    end
                    iptl_pkg::CmdLookup: begin
                        if (r_step != '0 && node_d.valid) begin
                            fin             = 1'b1;
                            res.found       = 1'b1;
                            res.match_value = node_d.value;
                        end else if (r_step == iptl_pkg::StepW'(iptl_pkg::KeyBits)) begin
                            fin = 1'b1;
                        end else if (child == '0) begin
                            fin = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            n_cur   = child;
                            n_fresh = 1'b0;
                            n_step  = r_step + iptl_pkg::StepW'(1);
                            n_key   = {r_key[iptl_pkg::KeyBits-2:0], 1'b0};
                        end
                    end
                    iptl_pkg::CmdClear: begin
                        n_root_ok   = 1'b0;
                        n_next_free = iptl_pkg::FreeW'(1);
                        fin         = 1'b1;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase

                if (wr_en && r_cur == '0) begin
                    n_root_ok = 1'b1;
                end

                if (fin) begin
                    o_res_valid = 1'b1;
                    o_res       = res;
                    n_hold      = res;
                    n_state     = i_res_ready ? S_IDLE : S_HOLD;
                end
            end

            S_HOLD: begin
                o_res_valid = 1'b1;
                o_res       = r_hold;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root_ok   <= 1'b0;
            r_next_free <= iptl_pkg::FreeW'(1);
            r_fresh     <= 1'b0;
            r_step      <= '0;
            r_cur       <= '0;
        end else begin
            r_state     <= n_state;
            r_root_ok   <= n_root_ok;
            r_next_free <= n_next_free;
            r_fresh     <= n_fresh;
            r_step      <= n_step;
            r_cur       <= n_cur;
            r_cmd       <= n_cmd;
            r_key       <= n_key;
            r_limit     <= n_limit;
            r_value     <= n_value;
            r_hold      <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_node_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cur] <= wr_data;
        end
    end

    // The free pointer never leaves the pool range.
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free != '0 && r_next_free <= iptl_pkg::FreeW'(iptl_pkg::NodeCount))
        else $error("free node pointer out of range");

    // A fresh node other than the root is always the one allocated last.
    a_fresh_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_fresh && r_cur != '0)
            |-> r_cur == new_idx - iptl_pkg::NodeIdxW'(1))
        else $error("fresh node is not the last allocated one");

    // A walk never goes deeper than the key.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_step <= iptl_pkg::StepW'(iptl_pkg::KeyBits))
        else $error("walk deeper than the key");

    // Lookups leave the node memory untouched.
    a_lookup_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_cmd == iptl_pkg::CmdLookup) |-> !wr_en)
        else $error("lookup wrote the node memory");

    // A held result stays put until the output side takes it.
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !i_res_ready) |=> (r_state == S_HOLD && $stable(r_hold)))
        else $error("held result lost");

endmodule

`default_nettype wire

### src/ipv4_prefix_trie_lookup.sv
// Top level of the IPv4 prefix trie lookup block: input handshake and the
// output register. Depends on iptl_pkg and iptl_engine.
//
// Usage. The input channel (i_valid, o_stall) carries one command per
// transfer: insert a prefix, look up an address, or clear the trie. Every
// command gives exactly one result transfer on the output channel
// (o_valid, i_stall) with found, match_value and status, in command order.
// Lookup reports the shortest stored prefix that matches the address; a value
// stored under a zero-length prefix sits at the root and is never reported.
//
// Walk. A command is taken and registered, then the walker descends one trie
// level at a time, each a dependent read through the registered read port of
// the node memory. Insert walks min(prefix_length, 32) levels deep, stopping
// early when the pool runs out; lookup stops at the first stored prefix, at
// the key's end or at a missing child; clear and unknown codes finish at once.
// The walker hands its result to the output register, and a new command can
// be taken once that hand-over is done, even while that result still waits.
//
// Reset empties the trie at once (the root is marked empty, the pool restarts
// at node one); no clearing pass runs. If the receiver stalls, the finished
// result waits in the output register, a second one waits inside the walker,
// and o_stall stays high until the walker can hand its result over.
`default_nettype none

module ipv4_prefix_trie_lookup (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [iptl_pkg::CmdW-1:0]           i_command,
    input  wire logic [iptl_pkg::KeyBits-1:0]        i_address,
    input  wire logic [iptl_pkg::PlenW-1:0]          i_prefix_length,
    input  wire logic [iptl_pkg::ValueBits-1:0]      i_entry_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_found,
    output logic [iptl_pkg::ValueBits-1:0]           o_match_value,
    output logic                                     o_status
);

    logic               busy;
    logic               res_valid;
    iptl_pkg::t_result  res;
    logic               res_ready;

    logic               r_out_valid;
    iptl_pkg::t_result  r_out;

    // The output register can take a result when it is empty or being drained.
    assign res_ready = !r_out_valid || !i_stall;
    assign o_stall   = busy;

    iptl_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_valid && !busy),
        .i_cmd           (i_command),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .i_entry_value   (i_entry_value),
        .o_busy          (busy),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .i_res_ready     (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_ready) begin
                r_out_valid <= res_valid;
                if (res_valid) begin
                    r_out <= res;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out.found;
    assign o_match_value = r_out.match_value;
    assign o_status      = r_out.status;

endmodule

`default_nettype wire
